// ===== hw/rtl/bfa_pkg.sv =====
// Shared types and constants of the bitmap frame allocator.
// No dependencies; imported by the interfaces, controller, datapath and top.
package bfa_pkg;

  localparam int unsigned FrameW  = 12;
  localparam int unsigned StatusW = 3;
  localparam int unsigned WordW   = 32;
  localparam int unsigned BitW    = 5;
  localparam int unsigned MaxWords = 128;

  localparam logic [StatusW-1:0] StAllocated = 3'd0;
  localparam logic [StatusW-1:0] StMapped    = 3'd1;
  localparam logic [StatusW-1:0] StNoFrame   = 3'd2;
  localparam logic [StatusW-1:0] StFreed     = 3'd3;
  localparam logic [StatusW-1:0] StNothing   = 3'd4;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

  typedef struct packed {
    logic               load;
    logic               scan_init;
    logic               scan_step;
    logic               alloc_wr;
    logic               free_wr;
    logic               res_load;
    logic [StatusW-1:0] res_code;
    logic               out_load;
  } bfa_cmd_t;

  typedef struct packed {
    logic kind_free;
    logic mapped;
    logic free_ok;
    logic chk_vld;
    logic found;
    logic scan_last;
  } bfa_sts_t;

endpackage

// ===== hw/rtl/bfa_if.sv =====
// Request and response channel interfaces of the frame allocator.
// Depends on bfa_pkg for field widths.
interface bfa_req_if import bfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [FrameW-1:0] entry_frame;
  logic              is_kernel;
  logic              is_writeable;

  modport source (output valid, kind, entry_frame, is_kernel, is_writeable, input ready);
  modport sink   (input valid, kind, entry_frame, is_kernel, is_writeable, output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [FrameW-1:0]  new_frame;
  logic               present;
  logic               rw;
  logic               user;

  modport source (output valid, status, new_frame, present, rw, user, input ready);
  modport sink   (input valid, status, new_frame, present, rw, user, output ready);
endinterface

// ===== hw/rtl/bfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bfa_ctrl.sv =====
// Controller state machine of the frame allocator.
// Depends on bfa_pkg; drives the datapath commands from its status.
module bfa_ctrl import bfa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  bfa_sts_t sts_i,
  output bfa_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    Idle,
    Eval,
    Scan,
    FreeWr,
    Done
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == Idle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      Idle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = Eval;
        end
      end
      Eval: begin
        if (sts_i.kind_free) begin
          if (sts_i.free_ok) begin
            state_d = FreeWr;
          end else begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_code = StNothing;
            state_d        = Done;
          end
        end else if (sts_i.mapped) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = StMapped;
          state_d        = Done;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = Scan;
        end
      end
      Scan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.chk_vld && sts_i.found) begin
          cmd_o.alloc_wr = 1'b1;
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = StAllocated;
          state_d        = Done;
        end else if (sts_i.chk_vld && sts_i.scan_last) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = StNoFrame;
          state_d        = Done;
        end
      end
      FreeWr: begin
        cmd_o.free_wr  = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_code = StFreed;
        state_d        = Done;
      end
      Done: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = Idle;
        end
      end
      default: state_d = Idle;
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/bfa_dp.sv =====
// Datapath of the frame allocator: request registers, bitmap RAM, scan
// counters, lowest-free-bit search and result registers. Depends on bfa_pkg, bfa_ram.
module bfa_dp import bfa_pkg::*; #(
  parameter int unsigned NUM_FRAMES = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bfa_cmd_t           cmd_i,
  output bfa_sts_t           sts_o,
  input  logic               kind_i,
  input  logic [FrameW-1:0]  entry_frame_i,
  input  logic               is_kernel_i,
  input  logic               is_writeable_i,
  output logic [StatusW-1:0] status_o,
  output logic [FrameW-1:0]  new_frame_o,
  output logic               present_o,
  output logic               rw_o,
  output logic               user_o
);

  localparam int unsigned BmWords   = (NUM_FRAMES + 31) / 32;
  localparam int unsigned MemWords  = (BmWords < MaxWords) ? BmWords : MaxWords;
  localparam int unsigned ScanWords = ((NUM_FRAMES / 32) < MaxWords) ?
                                      (NUM_FRAMES / 32) : MaxWords;
  localparam int unsigned Aw        = (MemWords > 1) ? $clog2(MemWords) : 1;
  localparam logic [Aw-1:0] LastIdx = Aw'(ScanWords - 1);

  logic              kind_q;
  logic [FrameW-1:0] frame_q;
  logic              kernel_q;
  logic              wr_q;

  logic [Aw-1:0]       rd_idx_q, word_idx_q, raddr, free_idx;
  logic                chk_vld_q;
  logic [MemWords-1:0] wvld_q;
  logic [WordW-1:0]    ram_rdata, word, zeros, low_oh, wdata;
  logic [BitW-1:0]     pos;
  logic                we;

  logic [StatusW-1:0] res_status_q;
  logic [FrameW-1:0]  res_frame_q;
  logic               res_present_q, res_rw_q, res_user_q;
  logic [StatusW-1:0] out_status_q;
  logic [FrameW-1:0]  out_frame_q;
  logic               out_present_q, out_rw_q, out_user_q;
  logic               is_alloc;

  assign free_idx = Aw'(frame_q >> BitW);
  assign raddr    = (kind_q == KindFree) ? free_idx : rd_idx_q;
  assign word     = wvld_q[word_idx_q] ? ram_rdata : '0;
  assign zeros    = ~word;
  assign low_oh   = zeros & (~zeros + WordW'(1));

  always_comb begin
    pos = '0;
    for (int b = 0; b < WordW; b++) begin
      if (low_oh[b]) begin
        pos = pos | BitW'(b);
      end
    end
  end

  assign we    = cmd_i.alloc_wr | cmd_i.free_wr;
  assign wdata = cmd_i.alloc_wr ? (word | low_oh)
                                : (word & ~(WordW'(1) << frame_q[BitW-1:0]));

  bfa_ram #(
    .Width (WordW),
    .Depth (MemWords)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (word_idx_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  assign sts_o.kind_free = (kind_q == KindFree);
  assign sts_o.mapped    = (frame_q != '0);
  assign sts_o.free_ok   = (frame_q != '0) && (32'(frame_q) < NUM_FRAMES);
  assign sts_o.chk_vld   = chk_vld_q;
  assign sts_o.found     = (word != '1);
  assign sts_o.scan_last = (word_idx_q == LastIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvld_q    <= '0;
      chk_vld_q <= 1'b0;
      rd_idx_q  <= '0;
    end else begin
      if (we) begin
        wvld_q[word_idx_q] <= 1'b1;
      end
      if (cmd_i.scan_init) begin
        rd_idx_q  <= '0;
        chk_vld_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        chk_vld_q <= 1'b1;
        if (rd_idx_q != LastIdx) begin
          rd_idx_q <= rd_idx_q + Aw'(1);
        end
      end
    end
  end

  assign is_alloc = (cmd_i.res_code == StAllocated);

  always_ff @(posedge clk_i) begin
    word_idx_q <= raddr;
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      frame_q  <= entry_frame_i;
      kernel_q <= is_kernel_i;
      wr_q     <= is_writeable_i;
    end
    if (cmd_i.res_load) begin
      res_status_q  <= cmd_i.res_code;
      res_present_q <= is_alloc;
      res_rw_q      <= is_alloc & wr_q;
      res_user_q    <= is_alloc & ~kernel_q;
      if (is_alloc) begin
        res_frame_q <= FrameW'({word_idx_q, pos});
      end else if (cmd_i.res_code == StMapped) begin
        res_frame_q <= frame_q;
      end else begin
        res_frame_q <= '0;
      end
    end
    if (cmd_i.out_load) begin
      out_status_q  <= res_status_q;
      out_frame_q   <= res_frame_q;
      out_present_q <= res_present_q;
      out_rw_q      <= res_rw_q;
      out_user_q    <= res_user_q;
    end
  end

  assign status_o    = out_status_q;
  assign new_frame_o = out_frame_q;
  assign present_o   = out_present_q;
  assign rw_o        = out_rw_q;
  assign user_o      = out_user_q;

endmodule

// ===== hw/rtl/bitmap_frame_allocator.sv =====
// Bitmap first-fit physical frame allocator, top level.
// Depends on bfa_pkg, bfa_if, bfa_ctrl, bfa_dp and bfa_ram.
//
// Requests arrive on req_i (kind, entry_frame, is_kernel, is_writeable); one
// response per request leaves on rsp_o (status, new_frame, present, rw, user).
// A transaction completes when valid and ready are both high at a clock edge.
// Requests are handled one at a time; req_i.ready is high while the
// controller is idle, also while a finished response waits in the output
// register. rsp_o.valid rises after the controller has passed Eval and Done
// for an already mapped entry or nothing to free, Eval, FreeWr and Done for
// a free, and Eval, Scan and Done for an allocation, where Scan lasts until
// the first free frame is found or the last word is checked. The scan reads
// one 32-bit word per cycle from the bitmap RAM read port, pipelined one
// word ahead, over min(NUM_FRAMES/32, 128) words; the next request can be
// taken in the cycle after the response is moved to the output register.
// Reset clears the per-word valid flags, so every frame reads free at once.
// If rsp_o stalls, the next result is held until the output register drains.
module bitmap_frame_allocator import bfa_pkg::*; #(
  parameter int unsigned NUM_FRAMES = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfa_req_if.sink   req_i,
  bfa_rsp_if.source rsp_o
);

  bfa_cmd_t cmd;
  bfa_sts_t sts;

  bfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bfa_dp #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_i         (req_i.kind),
    .entry_frame_i  (req_i.entry_frame),
    .is_kernel_i    (req_i.is_kernel),
    .is_writeable_i (req_i.is_writeable),
    .status_o       (rsp_o.status),
    .new_frame_o    (rsp_o.new_frame),
    .present_o      (rsp_o.present),
    .rw_o           (rsp_o.rw),
    .user_o         (rsp_o.user)
  );

endmodule

// ===== test/tb_bitmap_frame_allocator.sv =====
// Testbench for bitmap_frame_allocator: drives alloc and free requests and checks
// every response against a bitmap tracker kept in the testbench.
// Depends on bfa_pkg, bfa_if and the allocator RTL.
module tb_bitmap_frame_allocator import bfa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumFrames  = 4096;
  localparam int unsigned ScanWords  =
    ((NumFrames / WordW) < MaxWords) ? (NumFrames / WordW) : MaxWords;
  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned DrainWait  = 140;
  localparam int unsigned FillFrames = 64;

  typedef struct packed {
    logic              kind;
    logic [FrameW-1:0] entry_frame;
    logic              is_kernel;
    logic              is_writeable;
  } alloc_req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [FrameW-1:0]  new_frame;
    logic               present;
    logic               rw;
    logic               user;
  } alloc_rsp_t;

  class frame_usage_tracker;
    bit [WordW-1:0] used_words [MaxWords];
    int unsigned    used_total;
    alloc_rsp_t     expected_q [$];
    int unsigned    errors;

    function new();
      foreach (used_words[i]) used_words[i] = '0;
      used_total = 0;
      errors     = 0;
    endfunction

    function bit is_used(int unsigned f);
      return used_words[f / WordW][f % WordW];
    endfunction

    function bit lowest_free(output int unsigned f);
      for (int unsigned w = 0; w < ScanWords; w++) begin
        if (used_words[w] != '1) begin
          for (int unsigned b = 0; b < WordW; b++) begin
            if (!used_words[w][b]) begin
              f = w * WordW + b;
              return 1'b1;
            end
          end
        end
      end
      return 1'b0;
    endfunction

    function void note_request(alloc_req_t r);
      alloc_rsp_t  e;
      int unsigned f;
      e = '0;
      if (r.kind == KindAlloc) begin
        if (r.entry_frame != '0) begin
          e.status    = StMapped;
          e.new_frame = r.entry_frame;
        end else if (lowest_free(f)) begin
          used_words[f / WordW][f % WordW] = 1'b1;
          used_total++;
          e.status    = StAllocated;
          e.new_frame = f[FrameW-1:0];
          e.present   = 1'b1;
          e.rw        = r.is_writeable;
          e.user      = ~r.is_kernel;
        end else begin
          e.status = StNoFrame;
        end
      end else begin
        if (r.entry_frame == '0 || r.entry_frame >= NumFrames) begin
          e.status = StNothing;
        end else begin
          if (is_used(r.entry_frame)) used_total--;
          used_words[r.entry_frame / WordW][r.entry_frame % WordW] = 1'b0;
          e.status = StFreed;
        end
      end
      expected_q.push_back(e);
    endfunction

    function void check_response(alloc_rsp_t got);
      alloc_rsp_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected response: status %0d frame %0d", got.status, got.new_frame);
        return;
      end
      e = expected_q.pop_front();
      if (got.status != e.status || got.new_frame != e.new_frame ||
          got.present != e.present || got.rw != e.rw || got.user != e.user) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp st %0d fr %0d p%0b rw%0b u%0b, got st %0d fr %0d p%0b rw%0b u%0b",
                   e.status, e.new_frame, e.present, e.rw, e.user,
                   got.status, got.new_frame, got.present, got.rw, got.user);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count;
  frame_usage_tracker tracker;

  bfa_req_if req_bus ();
  bfa_rsp_if rsp_bus ();

  bitmap_frame_allocator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    rsp_bus.ready = rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : rsp_monitor
    alloc_rsp_t got;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      got.status    = rsp_bus.status;
      got.new_frame = rsp_bus.new_frame;
      got.present   = rsp_bus.present;
      got.rw        = rsp_bus.rw;
      got.user      = rsp_bus.user;
      tracker.check_response(got);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_bitmap_frame_allocator: errors");
      $finish;
    end
  end

  task automatic send_request(input logic kind, input logic [FrameW-1:0] frame,
                              input logic kern, input logic wr);
    alloc_req_t r;
    r = '{kind: kind, entry_frame: frame, is_kernel: kern, is_writeable: wr};
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid        = 1'b1;
    req_bus.kind         = r.kind;
    req_bus.entry_frame  = r.entry_frame;
    req_bus.is_kernel    = r.is_kernel;
    req_bus.is_writeable = r.is_writeable;
    do @(posedge clk_i); while (!req_bus.ready);
    tracker.note_request(r);
    @(negedge clk_i);
  endtask

  task automatic alloc_entry(input logic [FrameW-1:0] frame);
    send_request(KindAlloc, frame, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic free_entry(input logic [FrameW-1:0] frame);
    send_request(KindFree, frame, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned pick;
    int unsigned f;
    for (int unsigned i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        alloc_entry('0);
      end else if (pick < 75) begin
        f = $urandom_range(NumFrames - 1, 1);
        for (int t = 0; t < 8 && !tracker.is_used(f) && pick < 68; t++)
          f = $urandom_range(NumFrames - 1, 1);
        if (pick >= 70) f = $urandom_range(NumFrames - 1);
        free_entry(f[FrameW-1:0]);
      end else if (pick < 90) begin
        alloc_entry(12'($urandom_range(NumFrames - 1, 1)));
      end else begin
        send_request(1'($urandom_range(1)), 12'($urandom_range(NumFrames - 1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  initial begin
    tracker              = new();
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    rst_ni               = 1'b0;
    req_bus.valid        = 1'b0;
    req_bus.kind         = KindAlloc;
    req_bus.entry_frame  = '0;
    req_bus.is_kernel    = 1'b0;
    req_bus.is_writeable = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_request(KindFree,  12'd0,    1'b1, 1'b1);
    send_request(KindFree,  12'd4095, 1'b0, 1'b0);
    send_request(KindAlloc, 12'd0,    1'b0, 1'b0);
    send_request(KindAlloc, 12'd0,    1'b1, 1'b1);
    send_request(KindAlloc, 12'd0,    1'b0, 1'b1);
    send_request(KindAlloc, 12'd0,    1'b1, 1'b0);
    send_request(KindAlloc, 12'd4095, 1'b1, 1'b1);
    send_request(KindAlloc, 12'd1,    1'b0, 1'b0);
    send_request(KindAlloc, 12'hAAA,  1'b1, 1'b0);
    send_request(KindAlloc, 12'h555,  1'b0, 1'b1);
    send_request(KindFree,  12'd1,    1'b0, 1'b1);
    send_request(KindAlloc, 12'd0,    1'b1, 1'b1);
    send_request(KindFree,  12'd0,    1'b0, 1'b0);
    send_request(KindFree,  12'h800,  1'b1, 1'b0);
    send_request(KindFree,  12'h7FF,  1'b0, 1'b1);

    while (tracker.used_total < FillFrames) alloc_entry('0);
    alloc_entry('0);
    alloc_entry('0);
    free_entry(12'd4095);
    alloc_entry('0);
    alloc_entry('0);
    free_entry(12'd32);
    alloc_entry('0);

    set_idling(0, 0);
    run_random(250);
    set_idling(81, 0);
    run_random(250);
    set_idling(0, 81);
    run_random(250);
    set_idling(34, 34);
    run_random(250);

    req_bus.valid = 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.expected_q.size() == 0) begin
      $display("tb_bitmap_frame_allocator: clean");
    end else begin
      $display("tb_bitmap_frame_allocator: errors");
    end
    $finish;
  end

endmodule
